// ===== rtl/vector3_diff_normalize_or_zero_core_assert.svh =====
// Assertion macros for the vector difference normalizer.
`ifndef VECTOR3_DIFF_NORMALIZE_OR_ZERO_CORE_ASSERT_SVH
`define VECTOR3_DIFF_NORMALIZE_OR_ZERO_CORE_ASSERT_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define V3DN_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("v3dn: same-cycle check failed");

// ante holds in a cycle -> cons holds in the next cycle
`define V3DN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("v3dn: next-cycle check failed");

`endif

// ===== rtl/v3dn_pkg.sv =====
// Shared types and constants for the vector difference normalizer.
package v3dn_pkg;
   localparam int LANES = 3;
   localparam int QW = 15;   // quotient magnitude bits
   localparam int SW = 66;   // squared length bits
   localparam int RW = 98;   // remainder / partial product bits
   localparam int TW = 31;   // threshold bits
   localparam int FRONT_STAGES = 3;
   localparam int LATENCY = FRONT_STAGES + QW + 1;

   typedef struct packed {
      logic                      valid;
      logic                      zero;
      logic [LANES-1:0]          neg;
      logic [LANES-1:0][RW-1:0]  rem;
      logic [LANES-1:0][RW-1:0]  prod;
      logic [LANES-1:0][QW-1:0]  quo;
      logic [SW-1:0]             sum;
   } pipe_type;
endpackage

// ===== rtl/v3dn_front.sv =====
// Front stages: difference, squares, squared length and zero test.
module v3dn_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [31:0]            a [v3dn_pkg::LANES],
   input  logic signed [31:0]            b [v3dn_pkg::LANES],
   input  logic [v3dn_pkg::TW-1:0]       threshold,
   output v3dn_pkg::pipe_type            pipe_out
);
   logic                                 v1_ff, v2_ff;
   logic [v3dn_pkg::LANES-1:0]           neg1_ff, neg2_ff;
   logic [32:0]                          mag1_ff [v3dn_pkg::LANES];
   logic [32:0]                          mag1_in [v3dn_pkg::LANES];
   logic [v3dn_pkg::LANES-1:0]           neg1_in;
   logic [v3dn_pkg::SW-1:0]              sq2_ff [v3dn_pkg::LANES];
   logic [2*v3dn_pkg::TW-1:0]            t2_ff;
   logic [v3dn_pkg::SW-1:0]              sum_in;
   v3dn_pkg::pipe_type                   pipe_ff, pipe_in;

   always_comb begin
      logic signed [32:0] d;
      for (int i = 0; i < v3dn_pkg::LANES; i++) begin
         d = {a[i][31], a[i]} - {b[i][31], b[i]};
         neg1_in[i] = d[32];
         mag1_in[i] = d[32] ? 33'(-d) : 33'(d);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      neg1_ff <= neg1_in;
      neg2_ff <= neg1_ff;
      t2_ff   <= threshold * threshold;
      for (int i = 0; i < v3dn_pkg::LANES; i++) begin
         mag1_ff[i] <= mag1_in[i];
         sq2_ff[i]  <= {33'b0, mag1_ff[i]} * {33'b0, mag1_ff[i]};
      end
   end

   assign sum_in = sq2_ff[0] + sq2_ff[1] + sq2_ff[2];

   always_comb begin
      pipe_in.valid = v2_ff;
      pipe_in.zero  = (sum_in < {4'b0, t2_ff}) || (sum_in == '0);
      pipe_in.neg   = neg2_ff;
      pipe_in.sum   = sum_in;
      for (int i = 0; i < v3dn_pkg::LANES; i++) begin
         pipe_in.rem[i]  = {2'b0, sq2_ff[i], 30'b0};
         pipe_in.prod[i] = '0;
         pipe_in.quo[i]  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_ff.valid <= 1'b0;
      end else begin
         pipe_ff.valid <= pipe_in.valid;
      end
      pipe_ff.zero <= pipe_in.zero;
      pipe_ff.neg  <= pipe_in.neg;
      pipe_ff.rem  <= pipe_in.rem;
      pipe_ff.prod <= pipe_in.prod;
      pipe_ff.quo  <= pipe_in.quo;
      pipe_ff.sum  <= pipe_in.sum;
   end

   assign pipe_out = pipe_ff;
endmodule

// ===== rtl/v3dn_step.sv =====
// One quotient bit per lane: q^2*S <= d^2*2^30 tested by shift and subtract.
module v3dn_step #(
   parameter int BIT = v3dn_pkg::QW - 1
) (
   input  logic               clock,
   input  logic               reset,
   input  v3dn_pkg::pipe_type pipe_in,
   output v3dn_pkg::pipe_type pipe_out
);
   v3dn_pkg::pipe_type pipe_ff, next_in;

   always_comb begin
      logic [v3dn_pkg::RW-1:0] term;
      logic [v3dn_pkg::RW-1:0] sum_w;
      next_in = pipe_in;
      sum_w   = {{(v3dn_pkg::RW-v3dn_pkg::SW){1'b0}}, pipe_in.sum};
      for (int i = 0; i < v3dn_pkg::LANES; i++) begin
         term = (pipe_in.prod[i] << (BIT + 1)) + (sum_w << (2 * BIT));
         if (term <= pipe_in.rem[i]) begin
            next_in.rem[i]      = pipe_in.rem[i] - term;
            next_in.prod[i]     = pipe_in.prod[i] + (sum_w << BIT);
            next_in.quo[i][BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_ff.valid <= 1'b0;
      end else begin
         pipe_ff.valid <= next_in.valid;
      end
      pipe_ff.zero <= next_in.zero;
      pipe_ff.neg  <= next_in.neg;
      pipe_ff.rem  <= next_in.rem;
      pipe_ff.prod <= next_in.prod;
      pipe_ff.quo  <= next_in.quo;
      pipe_ff.sum  <= next_in.sum;
   end

   assign pipe_out = pipe_ff;
endmodule

// ===== rtl/vector3_diff_normalize_or_zero_core.sv =====
// Top level: normalized difference of two Q16.16 3-vectors, Q1.15 out.
//
//  channel   ports            handshake
//  request   start, req_*     accepted when start && !busy
//  response  rsp_*            rsp_valid strobe, one cycle, no stall
//  config    csr_we, csr_*    written when csr_we
//
// One word per cycle; the pipeline has 3 front stages, 15 quotient
// stages (one bit each, shift-subtract per lane) and 1 output register.
// busy is never raised. Synchronous reset clears all valid bits and sets
// the threshold to 66.
module vector3_diff_normalize_or_zero_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [31:0]           req_a_x,
   input  logic signed [31:0]           req_a_y,
   input  logic signed [31:0]           req_a_z,
   input  logic signed [31:0]           req_b_x,
   input  logic signed [31:0]           req_b_y,
   input  logic signed [31:0]           req_b_z,
   output logic                         rsp_valid,
   output logic signed [15:0]           rsp_unit_x,
   output logic signed [15:0]           rsp_unit_y,
   output logic signed [15:0]           rsp_unit_z,
   output logic                         rsp_zero_flag,
   input  logic                         csr_we,
   input  logic [v3dn_pkg::TW-1:0]      csr_wdata
);
`include "vector3_diff_normalize_or_zero_core_assert.svh"

   logic [v3dn_pkg::TW-1:0]  thresh_ff;
   logic signed [31:0]       a_arr [v3dn_pkg::LANES];
   logic signed [31:0]       b_arr [v3dn_pkg::LANES];
   v3dn_pkg::pipe_type       pipe [v3dn_pkg::QW+1];
   logic                     valid_ff, zero_ff;
   logic [15:0]              unit_ff [v3dn_pkg::LANES];
   logic [15:0]              unit_in [v3dn_pkg::LANES];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= v3dn_pkg::TW'(66);
      end else if (csr_we) begin
         thresh_ff <= csr_wdata;
      end
   end

   assign a_arr[0] = req_a_x;
   assign a_arr[1] = req_a_y;
   assign a_arr[2] = req_a_z;
   assign b_arr[0] = req_b_x;
   assign b_arr[1] = req_b_y;
   assign b_arr[2] = req_b_z;

   v3dn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .a         (a_arr),
      .b         (b_arr),
      .threshold (thresh_ff),
      .pipe_out  (pipe[0])
   );

   for (genvar g = 0; g < v3dn_pkg::QW; g++) begin : g_step
      v3dn_step #(.BIT(v3dn_pkg::QW - 1 - g)) u_step (
         .clock    (clock),
         .reset    (reset),
         .pipe_in  (pipe[g]),
         .pipe_out (pipe[g+1])
      );
   end

   always_comb begin
      for (int i = 0; i < v3dn_pkg::LANES; i++) begin
         if (pipe[v3dn_pkg::QW].zero) begin
            unit_in[i] = '0;
         end else if (pipe[v3dn_pkg::QW].neg[i]) begin
            unit_in[i] = 16'(-{1'b0, pipe[v3dn_pkg::QW].quo[i]});
         end else begin
            unit_in[i] = {1'b0, pipe[v3dn_pkg::QW].quo[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= pipe[v3dn_pkg::QW].valid;
      end
      zero_ff <= pipe[v3dn_pkg::QW].zero;
      for (int i = 0; i < v3dn_pkg::LANES; i++) begin
         unit_ff[i] <= unit_in[i];
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_zero_flag = zero_ff;
   assign rsp_unit_x    = unit_ff[0];
   assign rsp_unit_y    = unit_ff[1];
   assign rsp_unit_z    = unit_ff[2];

   `V3DN_ASSERT_NOW(a_zero_out, clock, reset, rsp_valid && rsp_zero_flag, rsp_unit_x == 16'sd0 && rsp_unit_y == 16'sd0 && rsp_unit_z == 16'sd0)
   `V3DN_ASSERT_NOW(a_no_minus_one, clock, reset, rsp_valid, rsp_unit_x != -16'sd32768 && rsp_unit_y != -16'sd32768 && rsp_unit_z != -16'sd32768)
   `V3DN_ASSERT_NOW(a_latency, clock, reset, rsp_valid, $past(start, v3dn_pkg::LATENCY))
   `V3DN_ASSERT_NEXT(a_last_valid, clock, reset, pipe[v3dn_pkg::QW].valid, rsp_valid)
endmodule
